### src/cdt_pkg.sv
// Package for the content directory table.
// Holds the operation and status codes used by the top level, and the types shared with the cell.
package cdt_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DEREGISTER = 2'd2;
  localparam logic [1:0] OP_LIST = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_HOLDS = 3'd4;
  localparam logic [2:0] ST_NOREG = 3'd5;
  localparam logic [2:0] ST_COUNT = 3'd6;
  localparam logic [2:0] ST_ENTRY = 3'd7;

  typedef struct packed {
    logic [63:0] peer;
    logic [63:0] content;
    logic [31:0] address;
    logic [15:0] port;
  } entry_t;

  // Commands from the sequencer to the cells: rotate and drop go to all, load and bump to one.
  typedef struct packed {
    logic rotate;
    logic load;
    logic bump;
    logic drop;
  } cell_ctrl_t;

endpackage

### src/cdt_cell.sv
// One table slot of the content directory table.
// Depends on cdt_pkg. The slots form a ring that rotates one place per cycle while rotate is set.
module cdt_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  cdt_pkg::cell_ctrl_t    ctrl,
  input  cdt_pkg::entry_t        load_entry,
  input  cdt_pkg::entry_t        next_entry,
  input  logic [COUNT_BITS-1:0]  next_count,
  input  logic                   drop_here,
  output cdt_pkg::entry_t        entry,
  output logic [COUNT_BITS-1:0]  count
);
  import cdt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= load_entry;
      count <= '0;
    end else if (ctrl.rotate) begin
      entry <= next_entry;
      count <= next_count;
    end else if (ctrl.drop && drop_here) begin
      entry <= next_entry;
      count <= next_count;
    end else if (ctrl.bump && count != '1) begin
      count <= count + 1'b1;
    end
  end

endmodule

### src/content_directory_table.sv
// Content directory table: a ring of cells holding up to ENTRIES entries.
// Register and search give their result word after a scan of every cell and a decide step;
// a deregister that finds its pair also passes a drop step; a list registers its count word
// on acceptance, then one entry word per cycle the receiver is ready, as the ring advances.
// One operation at a time: no word is taken while busy or while a result word is held.
// Synchronous reset empties the table and drops the output valid.
module content_directory_table #(
  parameter int ENTRIES = cdt_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = cdt_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] peer_name,
  input  logic [63:0] content_name,
  input  logic [31:0] peer_address,
  input  logic [15:0] peer_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] entry_peer,
  output logic [63:0] entry_content,
  output logic [31:0] entry_address,
  output logic [15:0] entry_port,
  output logic [5:0]  entry_total,
  output logic        last
);
  import cdt_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_DROP, S_LIST, S_WAIT} state_t;

  state_t state;
  logic [1:0] op_q;
  entry_t req;
  logic [5:0] used;
  logic [IW-1:0] step;
  logic [IW:0] lcnt;
  logic found, holds, pair_hit;
  logic [IW-1:0] best, pair_idx;
  logic [COUNT_BITS-1:0] best_count;
  cell_ctrl_t ctrl;
  logic [ENTRIES-1:0] bump_sel;
  logic list_adv;

  entry_t cell_e [ENTRIES];
  logic [COUNT_BITS-1:0] cell_c [ENTRIES];

  // Rotation moves each entry from cell i+1 into cell i, so cell 0
  // always presents index 'step' during a full revolution.
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      cell_ctrl_t c;
      always_comb begin
        c = ctrl;
        c.load = ctrl.load && (used[IW:0] == (IW+1)'(g));
        c.bump = bump_sel[g];
      end
      cdt_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
        .clk(clk), .ctrl(c), .load_entry(req),
        .next_entry(cell_e[(g+1)%ENTRIES]),
        .next_count(cell_c[(g+1)%ENTRIES]),
        .drop_here(IW'(g) >= pair_idx && (g + 1) < int'(used)),
        .entry(cell_e[g]), .count(cell_c[g])
      );
      assign bump_sel[g] = (state == S_DECIDE) && op_q == OP_SEARCH && found && !holds
                           && best == IW'(g);
    end
  endgenerate

  entry_t tap;
  logic [COUNT_BITS-1:0] tap_c;
  logic in_range;
  assign tap = cell_e[0];
  assign tap_c = cell_c[0];
  assign in_range = {1'b0, step} < used[IW:0];
  assign list_adv = (state == S_LIST) && (out_ready || !out_valid);

  always_comb begin
    ctrl = '0;
    ctrl.rotate = (state == S_SCAN) || list_adv;
    ctrl.load = (state == S_DECIDE) && op_q == OP_REGISTER && !pair_hit
                && used != 6'(ENTRIES);
    ctrl.drop = (state == S_DROP);
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_LIST) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_q <= op;
            req <= '{peer_name, content_name, peer_address, peer_port};
            step <= '0;
            found <= 1'b0;
            holds <= 1'b0;
            pair_hit <= 1'b0;
            best <= '0;
            pair_idx <= '0;
            best_count <= '0;
            lcnt <= '0;
            if (op == OP_LIST) begin
              status <= ST_COUNT;
              {entry_peer, entry_content, entry_address, entry_port} <= '0;
              entry_total <= used;
              last <= (used == '0);
              out_valid <= 1'b1;
              state <= (used == '0) ? S_WAIT : S_LIST;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (in_range) begin
            if (tap.content == req.content) begin
              if (tap.peer == req.peer) begin
                holds <= 1'b1;
                if (!pair_hit) pair_idx <= step;
                pair_hit <= 1'b1;
              end
              if (!found || tap_c < best_count) begin
                best <= step;
                best_count <= tap_c;
                found <= 1'b1;
              end
            end
          end
          step <= step + 1'b1;
          if (step == IW'(ENTRIES - 1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          {entry_peer, entry_content} <= '0;
          entry_total <= '0;
          last <= 1'b1;
          if (op_q == OP_SEARCH && found && !holds) begin
            entry_address <= cell_e[best].address;
            entry_port <= cell_e[best].port;
          end else begin
            entry_address <= '0;
            entry_port <= '0;
          end
          if (op_q == OP_DEREGISTER && pair_hit) begin
            state <= S_DROP;
          end else begin
            out_valid <= 1'b1;
            state <= S_WAIT;
          end
          case (op_q)
            OP_REGISTER: begin
              if (pair_hit) status <= ST_DUP;
              else if (used == 6'(ENTRIES)) status <= ST_FULL;
              else begin
                status <= ST_OK;
                used <= used + 1'b1;
              end
            end
            OP_SEARCH: begin
              if (!found) status <= ST_ABSENT;
              else if (holds) status <= ST_HOLDS;
              else status <= ST_OK;
            end
            default: begin
              status <= pair_hit ? ST_OK : ST_NOREG;
            end
          endcase
        end
        S_DROP: begin
          used <= used - 1'b1;
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_LIST: begin
          if (list_adv) begin
            if (lcnt < used[IW:0]) begin
              status <= ST_ENTRY;
              entry_peer <= tap.peer;
              entry_content <= tap.content;
              entry_address <= tap.address;
              entry_port <= tap.port;
              entry_total <= '0;
              last <= ((lcnt + 1'b1) == used[IW:0]);
            end else begin
              out_valid <= 1'b0;
            end
            lcnt <= lcnt + 1'b1;
            if (lcnt == (IW+1)'(ENTRIES - 1)) state <= S_WAIT;
          end
        end
        default: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (rst) used <= 6'(ENTRIES))
    else $error("entry count exceeds table depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("input taken while busy");
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> !ctrl.rotate && !ctrl.drop) else $error("conflicting cell commands");
  a_bump_single: assert property (@(posedge clk) disable iff (rst) $onehot0(bump_sel))
    else $error("more than one count bumped");
`endif

endmodule

### tb/sv/content_directory_table_test.sv
// Self-checking testbench for the content directory table.
// Drives register, search, deregister and list words and checks every result word
// against a predictor of the table kept here; depends on cdt_pkg and the block.
module content_directory_table_test;
  import cdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE = ENTRIES_DEF;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] peer;
    logic [63:0] content;
    logic [31:0] address;
    logic [15:0] port;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] peer;
    logic [63:0] content;
    logic [31:0] address;
    logic [15:0] port;
    logic [5:0]  total;
    logic        last;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_REGISTER;
  logic [63:0] peer_name = '0;
  logic [63:0] content_name = '0;
  logic [31:0] peer_address = '0;
  logic [15:0] peer_port = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [63:0] entry_peer;
  logic [63:0] entry_content;
  logic [31:0] entry_address;
  logic [15:0] entry_port;
  logic [5:0] entry_total;
  logic last;

  request_t pending_requests[$];
  reply_t expected_replies[$];
  int errors = 0;
  int cycles = 0;
  int sent_words = 0;
  bit idle_enable = 1'b1;
  bit long_hold_request = 1'b0;

  logic [63:0] dir_peer[TABLE_SIZE];
  logic [63:0] dir_content[TABLE_SIZE];
  logic [31:0] dir_address[TABLE_SIZE];
  logic [15:0] dir_port[TABLE_SIZE];
  logic [15:0] dir_served[TABLE_SIZE];
  int dir_used = 0;

  logic [63:0] peer_pool[6];
  logic [63:0] content_pool[6];

  content_directory_table i_dut (.*);

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int find_pair(input logic [63:0] p, input logic [63:0] c);
    for (int i = 0; i < dir_used; i++) begin
      if (dir_peer[i] == p && dir_content[i] == c) return i;
    end
    return -1;
  endfunction

  task automatic push_reply(input logic [2:0] st, input logic [63:0] p, input logic [63:0] c,
                            input logic [31:0] a, input logic [15:0] pt, input logic [5:0] tot,
                            input logic lst);
    reply_t r;
    r.status = st; r.peer = p; r.content = c; r.address = a; r.port = pt;
    r.total = tot; r.last = lst;
    expected_replies.push_back(r);
  endtask

  task automatic predict_directory(input request_t q);
    int idx;
    int best;
    bit holds;
    case (q.op)
      OP_REGISTER: begin
        if (find_pair(q.peer, q.content) >= 0) begin
          push_reply(ST_DUP, '0, '0, '0, '0, '0, 1'b1);
        end else if (dir_used >= TABLE_SIZE) begin
          push_reply(ST_FULL, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          dir_peer[dir_used] = q.peer;
          dir_content[dir_used] = q.content;
          dir_address[dir_used] = q.address;
          dir_port[dir_used] = q.port;
          dir_served[dir_used] = '0;
          dir_used++;
          push_reply(ST_OK, '0, '0, '0, '0, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        best = -1;
        holds = 1'b0;
        for (int i = 0; i < dir_used; i++) begin
          if (dir_content[i] == q.content) begin
            if (dir_peer[i] == q.peer) holds = 1'b1;
            if (best < 0 || dir_served[i] < dir_served[best]) best = i;
          end
        end
        if (best < 0) begin
          push_reply(ST_ABSENT, '0, '0, '0, '0, '0, 1'b1);
        end else if (holds) begin
          push_reply(ST_HOLDS, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          push_reply(ST_OK, '0, '0, dir_address[best], dir_port[best], '0, 1'b1);
          if (dir_served[best] != 16'hffff) dir_served[best]++;
        end
      end
      OP_DEREGISTER: begin
        idx = find_pair(q.peer, q.content);
        if (idx < 0) begin
          push_reply(ST_NOREG, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          for (int i = idx; i + 1 < dir_used; i++) begin
            dir_peer[i] = dir_peer[i + 1];
            dir_content[i] = dir_content[i + 1];
            dir_address[i] = dir_address[i + 1];
            dir_port[i] = dir_port[i + 1];
            dir_served[i] = dir_served[i + 1];
          end
          dir_used--;
          push_reply(ST_OK, '0, '0, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        push_reply(ST_COUNT, '0, '0, '0, '0, 6'(dir_used), dir_used == 0);
        for (int i = 0; i < dir_used; i++) begin
          push_reply(ST_ENTRY, dir_peer[i], dir_content[i], dir_address[i], dir_port[i],
                     '0, i + 1 == dir_used);
        end
      end
    endcase
  endtask

  // Driver: one word at a time from the pending queue, with random gaps while idle_enable is set.
  int send_gap = 0;
  always @(posedge clk) begin
    request_t q;
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        q.op = op; q.peer = peer_name; q.content = content_name;
        q.address = peer_address; q.port = peer_port;
        predict_directory(q);
        sent_words <= sent_words + 1;
        send_gap = idle_enable ? $urandom_range(0, 3) : 0;
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && pending_requests.size() > 0) begin
          q = pending_requests.pop_front();
          op <= q.op; peer_name <= q.peer; content_name <= q.content;
          peer_address <= q.address; peer_port <= q.port;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest expectation.
  int recv_hold = 0;
  always @(posedge clk) begin
    reply_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report($sformatf("unexpected word with status %0d", status));
        end else begin
          e = expected_replies.pop_front();
          if (status !== e.status) report($sformatf("status %0d, want %0d", status, e.status));
          if (entry_peer !== e.peer) report($sformatf("entry_peer %h, want %h", entry_peer, e.peer));
          if (entry_content !== e.content)
            report($sformatf("entry_content %h, want %h", entry_content, e.content));
          if (entry_address !== e.address)
            report($sformatf("entry_address %h, want %h", entry_address, e.address));
          if (entry_port !== e.port) report($sformatf("entry_port %h, want %h", entry_port, e.port));
          if (entry_total !== e.total)
            report($sformatf("entry_total %0d, want %0d", entry_total, e.total));
          if (last !== e.last) report($sformatf("last %b, want %b", last, e.last));
        end
        recv_hold = idle_enable ? $urandom_range(0, 3) : 0;
      end
      if (long_hold_request && recv_hold < 300) recv_hold = 300;
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_request(input logic [1:0] o, input logic [63:0] p, input logic [63:0] c,
                             input logic [31:0] a, input logic [15:0] pt);
    request_t q;
    q.op = o; q.peer = p; q.content = c; q.address = a; q.port = pt;
    pending_requests.push_back(q);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_peer();
    return ($urandom_range(0, 9) == 0) ? rand64() : peer_pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [63:0] pick_content();
    return ($urandom_range(0, 9) == 0) ? rand64() : content_pool[$urandom_range(0, 5)];
  endfunction

  task automatic add_random(input int register_weight, input int deregister_weight);
    int roll;
    logic [1:0] o;
    roll = $urandom_range(0, 99);
    if (roll < register_weight) o = OP_REGISTER;
    else if (roll < register_weight + deregister_weight) o = OP_DEREGISTER;
    else if (roll < 92) o = OP_SEARCH;
    else o = OP_LIST;
    add_request(o, pick_peer(), pick_content(), $urandom(), 16'($urandom()));
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid || expected_replies.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    peer_pool[0] = '0;
    peer_pool[1] = '1;
    content_pool[0] = '0;
    content_pool[1] = '1;
    for (int i = 2; i < 6; i++) begin
      peer_pool[i] = rand64();
      content_pool[i] = rand64();
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table: list, absent search, unknown deregister.
    add_request(OP_LIST, '0, '0, '0, '0);
    add_request(OP_SEARCH, '1, '1, '0, '0);
    add_request(OP_DEREGISTER, '0, '0, '0, '0);
    add_request(OP_REGISTER, '0, '0, '0, '0);
    add_request(OP_REGISTER, '1, '1, '1, '1);
    add_request(OP_REGISTER, '0, '0, '1, '1);
    add_request(OP_REGISTER, peer_pool[2], '1, 32'h0a000001, 16'd80);
    add_request(OP_REGISTER, peer_pool[3], '1, 32'h0a000002, 16'd81);
    // Holder search, then ties resolved by index and counts moving.
    add_request(OP_SEARCH, '1, '1, '0, '0);
    add_request(OP_SEARCH, peer_pool[4], '1, '0, '0);
    add_request(OP_SEARCH, peer_pool[4], '1, '0, '0);
    add_request(OP_SEARCH, peer_pool[5], '1, '0, '0);
    add_request(OP_SEARCH, peer_pool[5], content_pool[3], '0, '0);
    add_request(OP_LIST, '0, '0, '0, '0);
    // Remove the first holder; its followers shift down with their counts.
    add_request(OP_DEREGISTER, '1, '1, '0, '0);
    add_request(OP_SEARCH, peer_pool[4], '1, '0, '0);
    add_request(OP_SEARCH, peer_pool[4], '1, '0, '0);
    add_request(OP_LIST, '0, '0, '0, '0);
    add_request(OP_DEREGISTER, '0, '0, '0, '0);
    add_request(OP_LIST, '0, '0, '0, '0);
    // Fill the table past its capacity.
    for (int i = 0; i < 34; i++)
      add_request(OP_REGISTER, 64'(i + 16), pick_content(), $urandom(), 16'($urandom()));
    add_request(OP_REGISTER, '1, content_pool[4], '0, '0);
    add_request(OP_LIST, '0, '0, '0, '0);

    for (int i = 0; i < 60; i++) add_random(40, 5);
    wait (sent_words >= 60);
    long_hold_request = 1'b1;
    for (int i = 0; i < 8; i++) add_request(OP_LIST, '0, '0, '0, '0);
    repeat (300) @(posedge clk);
    long_hold_request = 1'b0;
    for (int i = 0; i < 60; i++) add_random(10, 45);
    wait_drained();
    repeat (40) @(posedge clk);
    idle_enable = 1'b0;
    for (int i = 0; i < 50; i++) add_random(35, 20);
    wait_drained();
    idle_enable = 1'b1;
    for (int i = 0; i < 70; i++) add_random(30, 25);
    wait_drained();
    repeat (100) @(posedge clk);
    if (expected_replies.size() != 0)
      report($sformatf("%0d result words never arrived", expected_replies.size()));
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/cdt_pkg.sv
src/cdt_cell.sv
src/content_directory_table.sv
tb/sv/content_directory_table_test.sv
